// ===== src/dipp_pkg.sv =====
// shared types, status codes and character constants for the dotted path parser
// no dependencies; used by dipp_step and dotted_identifier_path_parser_unit
package dipp_pkg;

	localparam longint unsigned MAX_PATH_LENGTH = 64'd65535;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_EMPTY       = 4'd1;
	localparam logic [3:0] ST_LEAD_DOT    = 4'd2;
	localparam logic [3:0] ST_TRAIL_DOT   = 4'd3;
	localparam logic [3:0] ST_SLASH       = 4'd4;
	localparam logic [3:0] ST_MISPLACED_Q = 4'd5;
	localparam logic [3:0] ST_NO_DOT_Q    = 4'd6;
	localparam logic [3:0] ST_EMPTY_COMP  = 4'd7;
	localparam logic [3:0] ST_UNMATCHED_Q = 4'd8;
	localparam logic [3:0] ST_EMPTY_QUOTE = 4'd9;
	localparam logic [3:0] ST_BAD_CHAR    = 4'd10;
	localparam logic [3:0] ST_LEAD_DIGIT  = 4'd11;

	localparam logic [7:0] CH_BACKTICK  = 8'h60;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	typedef struct packed {
		logic        in_quotes;
		logic        at_start;
		logic        just_closed;
		logic        quoted_has_text;
		logic        in_first;
		logic        lead_digit;
		logic [3:0]  split_code;
		logic [15:0] split_pos;
		logic [7:0]  split_char;
		logic [3:0]  check_code;
		logic [7:0]  check_char;
		logic        first_dot;
	} state_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        keep;
		logic        component_end;
		logic        done_res;
		logic [3:0]  status;
		logic [15:0] error_position;
		logic [7:0]  bad_char;
	} res_t;

	function automatic state_t state_reset();
		state_t s;
		s = '0;
		s.at_start = 1'b1;
		s.in_first = 1'b1;
		return s;
	endfunction

endpackage

// ===== src/dipp_step.sv =====
// per-beat scan logic: next parser state and result for one path byte
// depends on dipp_pkg
module dipp_step #(
	parameter longint unsigned MAX_PATH_LENGTH = dipp_pkg::MAX_PATH_LENGTH,
	localparam int unsigned ERR_POS_CAP =
		(MAX_PATH_LENGTH < 64'd65535) ? 32'(MAX_PATH_LENGTH) : 32'd65535,
	localparam int unsigned POS_W = $clog2(ERR_POS_CAP + 2)
) (
	input  logic [7:0]         byte_in,
	input  logic               is_last,
	input  logic               empty_path,
	input  dipp_pkg::state_t   st,
	input  logic [POS_W-1:0]   pos,
	output dipp_pkg::state_t   st_next,
	output logic [POS_W-1:0]   pos_next,
	output dipp_pkg::res_t     res
);

	function automatic logic is_digit(logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A)) || (c == dipp_pkg::CH_UNDERSCORE);
	endfunction

	function automatic dipp_pkg::state_t set_split(dipp_pkg::state_t s, logic [3:0] code,
			logic [15:0] p, logic [7:0] ch);
		dipp_pkg::state_t r;
		r = s;
		if (r.split_code == dipp_pkg::ST_OK) begin
			r.split_code = code;
			r.split_pos  = p;
			r.split_char = ch;
		end
		return r;
	endfunction

	function automatic dipp_pkg::state_t set_check(dipp_pkg::state_t s, logic [3:0] code,
			logic [7:0] ch);
		dipp_pkg::state_t r;
		r = s;
		if (r.check_code == dipp_pkg::ST_OK) begin
			r.check_code = code;
			r.check_char = ch;
		end
		return r;
	endfunction

	function automatic dipp_pkg::state_t finish_comp(dipp_pkg::state_t s);
		dipp_pkg::state_t r;
		r = s;
		if (r.in_first && r.lead_digit && (r.check_code == dipp_pkg::ST_OK))
			r.check_code = dipp_pkg::ST_LEAD_DIGIT;
		r.lead_digit      = 1'b0;
		r.in_first        = 1'b0;
		r.quoted_has_text = 1'b0;
		return r;
	endfunction

	dipp_pkg::state_t w;
	logic [15:0]      idx_cap;
	logic [15:0]      idx_prev;
	logic             unmatched;

	assign idx_cap  = (pos > POS_W'(ERR_POS_CAP)) ? 16'(ERR_POS_CAP) : 16'(pos);
	assign idx_prev = 16'(pos - POS_W'(1));

	always_comb begin
		w         = st;
		unmatched = 1'b0;
		res       = '0;
		res.byte_out = byte_in;
		pos_next  = (pos <= POS_W'(ERR_POS_CAP)) ? pos + POS_W'(1) : pos;

		if ((pos == '0) && (byte_in == dipp_pkg::CH_DOT))
			w.first_dot = 1'b1;

		if (w.just_closed) begin
			w.just_closed = 1'b0;
			if (byte_in != dipp_pkg::CH_DOT)
				w = set_split(w, dipp_pkg::ST_NO_DOT_Q, idx_prev, 8'd0);
		end
		if (((byte_in == dipp_pkg::CH_SLASH) || (byte_in == dipp_pkg::CH_BACKSLASH)) &&
				!w.in_quotes)
			w = set_split(w, dipp_pkg::ST_SLASH, idx_cap, byte_in);

		if (byte_in == dipp_pkg::CH_BACKTICK) begin
			if (!w.in_quotes) begin
				if (!w.at_start) begin
					w = set_split(w, dipp_pkg::ST_MISPLACED_Q, idx_cap, 8'd0);
				end else begin
					w.in_quotes       = 1'b1;
					w.quoted_has_text = 1'b0;
				end
			end else begin
				w.in_quotes   = 1'b0;
				w.just_closed = 1'b1;
				if (!w.quoted_has_text)
					w = set_check(w, dipp_pkg::ST_EMPTY_QUOTE, 8'd0);
			end
			w.at_start = 1'b0;
		end else if ((byte_in == dipp_pkg::CH_DOT) && !w.in_quotes) begin
			if (w.at_start) begin
				w = set_split(w, dipp_pkg::ST_EMPTY_COMP, idx_cap, 8'd0);
			end else begin
				w = finish_comp(w);
				w.at_start = 1'b1;
			end
			res.component_end = 1'b1;
		end else begin
			res.keep = 1'b1;
			if (w.in_quotes) begin
				w.quoted_has_text = 1'b1;
			end else begin
				if (w.at_start && w.in_first && is_digit(byte_in)) begin
					w.lead_digit = 1'b1;
					if (w.check_code == dipp_pkg::ST_OK)
						w.check_char = byte_in;
				end
				if (!is_word(byte_in))
					w = set_check(w, dipp_pkg::ST_BAD_CHAR, byte_in);
			end
			w.at_start = 1'b0;
		end

		st_next = w;

		if (is_last) begin
			unmatched = w.in_quotes;
			if (w.in_first)
				w = finish_comp(w);
			res.component_end = 1'b1;
			res.done_res      = 1'b1;
			if (w.first_dot) begin
				res.status = dipp_pkg::ST_LEAD_DOT;
			end else if (byte_in == dipp_pkg::CH_DOT) begin
				res.status = dipp_pkg::ST_TRAIL_DOT;
			end else if (w.split_code != dipp_pkg::ST_OK) begin
				res.status         = w.split_code;
				res.error_position = w.split_pos;
				res.bad_char       = w.split_char;
			end else if (unmatched) begin
				res.status = dipp_pkg::ST_UNMATCHED_Q;
			end else if (w.check_code != dipp_pkg::ST_OK) begin
				res.status   = w.check_code;
				res.bad_char = w.check_char;
			end
			st_next  = dipp_pkg::state_reset();
			pos_next = '0;
		end

		if (empty_path) begin
			res          = '0;
			res.done_res = 1'b1;
			res.status   = dipp_pkg::ST_EMPTY;
			st_next      = dipp_pkg::state_reset();
			pos_next     = '0;
		end
	end

endmodule

// ===== src/dotted_identifier_path_parser_unit.sv =====
// channel    | handshake            | payload
// in         | in_valid / in_ready  | byte_in, is_last, empty_path
// out        | out_valid / out_ready| byte_out, keep, component_end, done_res,
//            |                      | status, error_position, bad_char
// one beat per cycle sustained while out_ready holds; each beat passes through the input register
// and the scan logic, then sits in the result register until taken
// the parser state updates as a beat moves from input to result register
// reset clears the valid bits and parser state; payload registers are not reset
// a stalled result register holds the input register, which keeps taking a beat
// while empty; depends on dipp_pkg and dipp_step
module dotted_identifier_path_parser_unit #(
	parameter longint unsigned MAX_PATH_LENGTH = dipp_pkg::MAX_PATH_LENGTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        is_last,
	input  logic        empty_path,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte_out,
	output logic        keep,
	output logic        component_end,
	output logic        done_res,
	output logic [3:0]  status,
	output logic [15:0] error_position,
	output logic [7:0]  bad_char
);

	localparam int unsigned ERR_POS_CAP =
		(MAX_PATH_LENGTH < 64'd65535) ? 32'(MAX_PATH_LENGTH) : 32'd65535;
	localparam int unsigned POS_W = $clog2(ERR_POS_CAP + 2);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             empty_s1;
	logic             valid_s2;
	dipp_pkg::res_t   res_s2;
	dipp_pkg::res_t   res_d;
	dipp_pkg::state_t state_q;
	dipp_pkg::state_t state_d;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_d;
	logic             load_s2;
	logic             accept;

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;
	assign accept   = in_valid && in_ready;

	dipp_step #(
		.MAX_PATH_LENGTH(MAX_PATH_LENGTH)
	) u_step (
		.byte_in   (byte_s1),
		.is_last   (last_s1),
		.empty_path(empty_s1),
		.st        (state_q),
		.pos       (pos_q),
		.st_next   (state_d),
		.pos_next  (pos_d),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= dipp_pkg::state_reset();
			pos_q    <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (load_s2)
				valid_s1 <= 1'b0;
			if (load_s2)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
			if (load_s2) begin
				state_q <= state_d;
				pos_q   <= pos_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= byte_in;
			last_s1  <= is_last;
			empty_s1 <= empty_path;
		end
		if (load_s2)
			res_s2 <= res_d;
	end

	assign out_valid      = valid_s2;
	assign byte_out       = res_s2.byte_out;
	assign keep           = res_s2.keep;
	assign component_end  = res_s2.component_end;
	assign done_res       = res_s2.done_res;
	assign status         = res_s2.status;
	assign error_position = res_s2.error_position;
	assign bad_char       = res_s2.bad_char;

`ifndef SYNTH
	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.status == dipp_pkg::ST_OK || res_s2.done_res))
		else $error("status reported on a beat that is not last");

	a_epos_split_only: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.error_position != 16'd0) |->
		(res_s2.status == dipp_pkg::ST_SLASH || res_s2.status == dipp_pkg::ST_MISPLACED_Q ||
		res_s2.status == dipp_pkg::ST_NO_DOT_Q || res_s2.status == dipp_pkg::ST_EMPTY_COMP))
		else $error("error position set without a split error");

	a_state_cleared_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && (last_s1 || empty_s1)) |=> (pos_q == '0 && state_q.at_start))
		else $error("parser state not cleared after end of path");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(ERR_POS_CAP + 1))
		else $error("position counter ran past its cap");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2 && !out_ready))
		else $error("input stalled without a blocked result");
`endif

endmodule
